@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// Each macro wraps one concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define TAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion that is checked on every edge, reset included.
`define TAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ sv/tau_pkg.sv @@
// Shared types, codes and constants of the triangle area unit.
// No dependencies; every module file of the project imports this package.
`default_nettype none

package tau_pkg;

    // Command codes carried in the cmd field of a request.
    typedef enum logic [1:0] {
        CMD_BASE_HEIGHT = 2'd0,
        CMD_SIDE_ANGLE  = 2'd1,
        CMD_HERON       = 2'd2,
        CMD_INVALID     = 2'd3
    } tau_cmd_t;

    // One request: lengths are signed Q8.8, the angle is in 1/128 degree.
    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  side_a;
        logic signed [15:0]  side_b;
        logic signed [15:0]  third_length;
        logic signed [15:0]  angle_deg;
    } tau_req_t;

    // One result: unsigned Q13.16 area and its valid flag.
    typedef struct packed {
        logic [28:0] area;
        logic        valid_res;
    } tau_res_t;

    // Pipeline depths.
    localparam int HORNER_STEPS = 7;
    localparam int SINE_LAT     = 3 * HORNER_STEPS + 5;
    localparam int HERON_LAT    = 35;
    localparam int PIPE_LAT     = HERON_LAT;
    localparam int SINE_PAD     = PIPE_LAT - SINE_LAT;

    // Angle limits: 180 and 90 degrees in 1/128 degree units.
    localparam logic [14:0] ANGLE_LIMIT = 15'd23040;
    localparam logic [14:0] ANGLE_HALF  = 15'd11520;

    // Degrees to radians: x = t * PI_Q44 / X_DIV, split into integer and fraction.
    localparam logic [63:0] PI_Q44    = 64'h0000_3243_F6A8_885A;
    localparam logic [63:0] X_DIV_W   = 64'd377487360;
    localparam logic [63:0] X_INT_W   = PI_Q44 / X_DIV_W;
    localparam logic [63:0] X_REM_W   = PI_Q44 % X_DIV_W;
    localparam logic [63:0] X_FRAC_W  = (X_REM_W << 32) / X_DIV_W;
    localparam logic [17:0] X_INT     = X_INT_W[17:0];
    localparam logic [28:0] X_REM     = X_REM_W[28:0];
    localparam logic [28:0] X_DIV     = X_DIV_W[28:0];
    localparam logic [31:0] X_FRAC    = X_FRAC_W[31:0];

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [28:0] AREA_MAX = 29'h1FFF_FFFF;

    // Horner divisor of a step, from the highest term down: (2k)(2k+1).
    function automatic logic [7:0] horner_div(input int step);
        int k;
        k = HORNER_STEPS - step;
        return 8'(2 * k * (2 * k + 1));
    endfunction

endpackage

`default_nettype wire

@@ sv/tau_sine.sv @@
// Side-angle area datapath: a*b*sin(t)/2 with a Horner sine polynomial.
// Depends on tau_pkg; the pipeline advances only while en is high.
`default_nettype none

module tau_sine import tau_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [14:0] side_a,
    input  logic [14:0] side_b,
    input  logic [13:0] turn,
    output logic [29:0] area
);

    localparam int CAR_LEN = 3 * HORNER_STEPS + 1;

    typedef struct packed {
        logic [29:0] ab;
        logic [30:0] x;
        logic [31:0] x2;
    } carry_t;

    logic [29:0] ab_reg, ab2_reg;
    logic [31:0] xi_reg;
    logic [13:0] est_reg;
    logic [42:0] tb_reg;
    logic [30:0] x_reg;
    carry_t      car_reg [CAR_LEN];
    logic [31:0] m_reg  [HORNER_STEPS];
    logic [31:0] mq_reg [HORNER_STEPS];
    logic [31:0] q_reg  [HORNER_STEPS];
    logic [30:0] r_reg  [HORNER_STEPS];
    logic [30:0] s_reg;
    logic [29:0] abf_reg;
    logic [29:0] area_reg;

    logic [29:0] ab_next;
    logic [31:0] xi_next;
    logic [45:0] tf_prod;
    logic [42:0] tb_next;
    logic [42:0] ed_prod;
    logic [42:0] rem_x;
    logic [30:0] x_next;
    logic [61:0] xx_prod;
    logic [61:0] s_prod;
    logic [60:0] area_prod;

    // Stage 1: a*b and the radian conversion products.
    always_comb
    begin
        ab_next = 30'(side_a) * 30'(side_b);
        xi_next = 32'(turn) * 32'(X_INT);
        tf_prod = 46'(turn) * 46'(X_FRAC);
        tb_next = 43'(turn) * 43'(X_REM);
    end

    // Stage 2: correct the fractional quotient by one compare.
    always_comb
    begin
        ed_prod = 43'(est_reg) * 43'(X_DIV);
        rem_x   = tb_reg - ed_prod;
        x_next  = 31'(xi_reg) + 31'(est_reg) + 31'(rem_x >= 43'(X_DIV));
    end

    // Stage 3: square of the angle in Q30.
    assign xx_prod = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_reg  <= ab_next;
            xi_reg  <= xi_next;
            est_reg <= tf_prod[45:32];
            tb_reg  <= tb_next;
            ab2_reg <= ab_reg;
            x_reg   <= x_next;
            car_reg[0].ab <= ab2_reg;
            car_reg[0].x  <= x_reg;
            car_reg[0].x2 <= xx_prod[61:30];
        end
    end

    // Operands travel alongside the Horner steps.
    for (genvar i = 1; i < CAR_LEN; i++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                car_reg[i] <= car_reg[i-1];
            end
        end
    end

    // Horner steps: multiply, divide by a constant, subtract from one.
    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_horner
        localparam logic [7:0]  HDIV    = horner_div(j);
        localparam logic [63:0] RECIP_W = (64'd1 << 32) / {56'd0, HDIV};
        localparam logic [31:0] RECIP   = RECIP_W[31:0];

        logic [30:0] r_in;
        logic [62:0] m_prod;
        logic [63:0] q_prod;
        logic [39:0] qd_prod;
        logic [31:0] rem_q;
        logic [31:0] term;

        if (j == 0)
        begin : g_first
            assign r_in = ONE_Q30;
        end
        else
        begin : g_next
            assign r_in = r_reg[j-1];
        end

        always_comb
        begin
            m_prod  = 63'(car_reg[3*j].x2) * 63'(r_in);
            q_prod  = 64'(m_reg[j]) * 64'(RECIP);
            qd_prod = 40'(q_reg[j]) * 40'(HDIV);
            rem_q   = mq_reg[j] - qd_prod[31:0];
            term    = q_reg[j] + 32'(rem_q >= 32'(HDIV));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[j]  <= m_prod[61:30];
                q_reg[j]  <= q_prod[63:32];
                mq_reg[j] <= m_reg[j];
                if (term >= 32'(ONE_Q30))
                begin
                    r_reg[j] <= '0;
                end
                else
                begin
                    r_reg[j] <= ONE_Q30 - term[30:0];
                end
            end
        end
    end

    // Final stages: sine = x*r, then a*b*sine halved and scaled to Q16.
    always_comb
    begin
        s_prod    = 62'(car_reg[CAR_LEN-1].x) * 62'(r_reg[HORNER_STEPS-1]);
        area_prod = 61'(abf_reg) * 61'(s_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_prod[60:30];
            abf_reg  <= car_reg[CAR_LEN-1].ab;
            area_reg <= area_prod[60:31];
        end
    end

    assign area = area_reg;

endmodule

`default_nettype wire

@@ sv/tau_heron.sv @@
// Heron area datapath: four-factor product and a 32-stage square root.
// Depends on tau_pkg; the pipeline advances only while en is high.
`default_nettype none

module tau_heron import tau_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [14:0] side_a,
    input  logic [14:0] side_b,
    input  logic [14:0] side_c,
    output logic [30:0] area
);

    localparam int ROOT_STEPS = 32;

    logic [33:0] u_reg, v_reg;
    logic [50:0] lo_reg, hi_reg;
    logic [63:0] prod_reg;
    logic [63:0] rem_reg  [ROOT_STEPS];
    logic [63:0] root_reg [ROOT_STEPS];

    logic [16:0] sum_p, sum_q1, sum_q2, sum_q3;
    logic [33:0] u_next, v_next;
    logic [50:0] lo_next, hi_next;

    // Stage 1: the four sums and two pairwise products.
    always_comb
    begin
        sum_p   = 17'(side_a) + 17'(side_b) + 17'(side_c);
        sum_q1  = 17'(side_b) + 17'(side_c) - 17'(side_a);
        sum_q2  = 17'(side_a) + 17'(side_c) - 17'(side_b);
        sum_q3  = 17'(side_a) + 17'(side_b) - 17'(side_c);
        u_next  = 34'(sum_p) * 34'(sum_q1);
        v_next  = 34'(sum_q2) * 34'(sum_q3);
        lo_next = 51'(u_reg) * 51'(v_reg[16:0]);
        hi_next = 51'(u_reg) * 51'(v_reg[33:17]);
    end

    // Stages 2 and 3: wide product from two partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            prod_reg <= {13'd0, lo_reg} + {hi_reg[46:0], 17'd0};
        end
    end

    // Square root, one result bit per stage.
    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);

        logic [63:0] rem_in, root_in, trial;

        if (i == 0)
        begin : g_first
            assign rem_in  = prod_reg;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        assign trial = root_in + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[i]  <= rem_in - trial;
                    root_reg[i] <= (root_in >> 1) + BIT;
                end
                else
                begin
                    rem_reg[i]  <= rem_in;
                    root_reg[i] <= root_in >> 1;
                end
            end
        end
    end

    assign area = root_reg[ROOT_STEPS-1][32:2];

endmodule

`default_nettype wire

@@ sv/triangle_area_unit.sv @@
// Top level of the triangle area unit: request decode, pipeline control, result merge.
// Depends on tau_pkg, tau_sine and tau_heron.
`default_nettype none

// Computes one triangle area per request: base times height over two, two sides
// and the included angle, or Heron's formula, selected by cmd. Requests enter at
// one per cycle while req_stall is low, and the pipeline depth is set by the
// 32-stage square root of the Heron path. Results come out in request order.
// When the output register holds a result that is stalled, the whole pipeline
// holds and req_stall is raised. The block keeps no state between requests and
// needs no clearing after reset.
module triangle_area_unit import tau_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  tau_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output tau_res_t res
);

    typedef struct packed {
        logic        ok;
        logic [1:0]  cmd;
        logic [28:0] area0;
    } meta_t;

    logic        en;
    logic        vld_reg  [PIPE_LAT];
    meta_t       meta_reg [PIPE_LAT];
    logic [29:0] pad_reg  [SINE_PAD];
    logic        res_valid_reg;
    tau_res_t    res_reg;

    logic        neg_a, neg_b, neg_c, neg_ang;
    logic [16:0] ext_a, ext_b, ext_c;
    logic [14:0] ang;
    logic [13:0] turn;
    logic [29:0] bh_prod;
    meta_t       meta_next;
    logic [29:0] sine_area;
    logic [30:0] heron_area;
    meta_t       meta_out;
    tau_res_t    res_next;

    // The pipeline moves unless a finished result waits at the output.
    assign en        = !(res_valid_reg && res_stall);
    assign req_stall = !en;

    // Operand checks and the base-height product.
    always_comb
    begin
        neg_a   = req.side_a[15];
        neg_b   = req.side_b[15];
        neg_c   = req.third_length[15];
        neg_ang = req.angle_deg[15];
        ext_a   = 17'(req.side_a[14:0]);
        ext_b   = 17'(req.side_b[14:0]);
        ext_c   = 17'(req.third_length[14:0]);
        ang     = req.angle_deg[14:0];
        if (ang < ANGLE_HALF)
        begin
            turn = ang[13:0];
        end
        else
        begin
            turn = 14'(ANGLE_LIMIT - ang);
        end
        bh_prod = 30'(req.side_b[14:0]) * 30'(req.third_length[14:0]);

        meta_next.cmd   = req.cmd;
        meta_next.area0 = bh_prod[29:1];
        unique case (req.cmd)
            CMD_BASE_HEIGHT:
                meta_next.ok = !neg_b && !neg_c;
            CMD_SIDE_ANGLE:
                meta_next.ok = !neg_a && !neg_b && !neg_ang && (ang < ANGLE_LIMIT);
            CMD_HERON:
                meta_next.ok = !neg_a && !neg_b && !neg_c
                               && (ext_a < ext_b + ext_c)
                               && (ext_b < ext_a + ext_c)
                               && (ext_c < ext_a + ext_b);
            default:
                meta_next.ok = 1'b0;
        endcase
    end

    tau_sine u_sine (
        .clk    (clk),
        .en     (en),
        .side_a (req.side_a[14:0]),
        .side_b (req.side_b[14:0]),
        .turn   (turn),
        .area   (sine_area)
    );

    tau_heron u_heron (
        .clk    (clk),
        .en     (en),
        .side_a (req.side_a[14:0]),
        .side_b (req.side_b[14:0]),
        .side_c (req.third_length[14:0]),
        .area   (heron_area)
    );

    // Valid bits travel with the request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= req_valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Mode, verdict and the base-height area wait for the long datapaths; the sine area is padded to the Heron depth.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_next;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
            pad_reg[0] <= sine_area;
            for (int i = 1; i < SINE_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    // Pick the area of the selected mode and clamp it to the output range.
    always_comb
    begin
        meta_out = meta_reg[PIPE_LAT-1];
        res_next.valid_res = meta_out.ok;
        res_next.area      = '0;
        if (meta_out.ok)
        begin
            unique case (meta_out.cmd)
                CMD_BASE_HEIGHT:
                    res_next.area = meta_out.area0;
                CMD_SIDE_ANGLE:
                    res_next.area = (pad_reg[SINE_PAD-1] > 30'(AREA_MAX))
                                    ? AREA_MAX : pad_reg[SINE_PAD-1][28:0];
                CMD_HERON:
                    res_next.area = (heron_area > 31'(AREA_MAX))
                                    ? AREA_MAX : heron_area[28:0];
                default:
                    res_next.area = '0;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ sv/tau_checker.sv @@
// Port-level checks of the triangle area unit, bound to the top level.
// Depends on tau_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tau_checker import tau_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input tau_req_t req,
    input logic     res_valid,
    input logic     res_stall,
    input tau_res_t res
);

    // The input side is only held back by a stalled result.
    `TAU_ASSERT(a_stall_cause, clk, rst_n, req_stall |-> (res_valid && res_stall), "request stalled without a waiting result")

    // A stalled request stays offered and unchanged.
    `TAU_ASSERT(a_req_held, clk, rst_n, (req_valid && req_stall) |=> (req_valid && $stable(req)), "stalled request changed")

    // A rejected request reports a zero area.
    `TAU_ASSERT(a_invalid_zero, clk, rst_n, (res_valid && !res.valid_res) |-> (res.area == 29'd0), "invalid result with nonzero area")

    // A stalled result stays in place.
    `TAU_ASSERT(a_result_held, clk, rst_n, (res_valid && res_stall) |=> (res_valid && $stable(res)), "stalled result changed")

    // No result is offered while reset is held.
    `TAU_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !res_valid, "result valid during reset")

endmodule

bind triangle_area_unit tau_checker u_tau_checker (.*);

`default_nettype wire

@@ dv/tb_triangle_area_unit.sv @@
// Self-checking testbench of triangle_area_unit: directed table, then random requests.
// Depends on tau_pkg and the RTL of the block; expected areas come from a local predictor.
`timescale 1ns / 1ps

module tb_triangle_area_unit;
    import tau_pkg::*;

    localparam int N_RANDOM   = 870;
    localparam int DRAIN_WAIT = 80;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    tau_req_t req;
    logic     res_valid;
    logic     res_stall;
    tau_res_t res;

    triangle_area_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tau_res_t pending_areas[$];
    int       n_errors;
    int       n_checked;
    int       n_valid_seen;
    bit       stim_done;
    bit       hold_off;

    // Sine of a folded angle in Q30, by a truncated Horner polynomial.
    function automatic logic [63:0] sine_of_angle(input logic [63:0] t);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] d;
        logic [63:0] term;
        x  = (t * PI_Q44) / (64'd23040 << 14);
        x2 = (x * x) >> 30;
        r  = 64'd1 << 30;
        for (int k = 7; k >= 1; k--)
        begin
            d    = 64'(2 * k * (2 * k + 1));
            term = ((x2 * r) >> 30) / d;
            r    = (term >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - term;
        end
        return (x * r) >> 30;
    endfunction

    // Bit-serial integer square root over 32 steps.
    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] bitv;
        acc  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= acc + bitv)
            begin
                v   = v - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc = acc >> 1;
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    // Expected area and flag of one request.
    function automatic tau_res_t predict_area(input tau_req_t r);
        longint      a;
        longint      b;
        longint      c;
        longint      ang;
        logic [63:0] t;
        logic [63:0] prod;
        logic [63:0] ar;
        bit          ok;
        tau_res_t    o;
        a   = r.side_a;
        b   = r.side_b;
        c   = r.third_length;
        ang = r.angle_deg;
        ar  = 64'd0;
        ok  = 1'b0;
        case (tau_cmd_t'(r.cmd))
            CMD_BASE_HEIGHT:
                if (b >= 0 && c >= 0)
                begin
                    ar = (64'(b) * 64'(c)) >> 1;
                    ok = 1'b1;
                end
            CMD_SIDE_ANGLE:
                if (a >= 0 && b >= 0 && ang >= 0 && ang < 23040)
                begin
                    t  = (ang < 11520) ? 64'(ang) : 64'(23040 - ang);
                    ar = (64'(a) * 64'(b) * sine_of_angle(t)) >> 31;
                    ok = 1'b1;
                end
            CMD_HERON:
                if (a >= 0 && b >= 0 && c >= 0 && a < b + c && b < a + c && c < a + b)
                begin
                    prod = 64'(a + b + c) * 64'(b + c - a) * 64'(a + c - b)
                           * 64'(a + b - c);
                    ar = root_of(prod) >> 2;
                    ok = 1'b1;
                end
            default: ok = 1'b0;
        endcase
        if (ar > 64'(AREA_MAX))
            ar = 64'(AREA_MAX);
        o.area      = ok ? ar[28:0] : 29'd0;
        o.valid_res = ok;
        return o;
    endfunction

    // Directed table; a row with has_exp set carries an expected result read off by hand.
    typedef struct {
        tau_req_t r;
        bit       has_exp;
        tau_res_t e;
    } dir_row_t;

    function automatic tau_req_t mk(input tau_cmd_t cm, input int a, input int b,
                                    input int c, input int g);
        tau_req_t r;
        r.cmd          = cm;
        r.side_a       = 16'(a);
        r.side_b       = 16'(b);
        r.third_length = 16'(c);
        r.angle_deg    = 16'(g);
        return r;
    endfunction

    function automatic dir_row_t row(input tau_req_t r, input bit he,
                                     input logic [28:0] ar, input bit v);
        dir_row_t d;
        d.r           = r;
        d.has_exp     = he;
        d.e.area      = ar;
        d.e.valid_res = v;
        return d;
    endfunction

    // Random request, mostly well formed, lengths usually small.
    function automatic tau_req_t random_request();
        tau_req_t r;
        int       s;
        r.cmd          = 2'($urandom_range(0, 3));
        r.side_a       = 16'($urandom);
        r.side_b       = 16'($urandom);
        r.third_length = 16'($urandom);
        r.angle_deg    = 16'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            r.cmd = 2'($urandom_range(0, 2));
            s = $urandom_range(0, 3) == 0 ? 32767 : 4095;
            r.side_a       = 16'($urandom_range(0, s));
            r.side_b       = 16'($urandom_range(0, s));
            r.third_length = 16'($urandom_range(0, s));
            r.angle_deg    = 16'($urandom_range(0, 23039));
            // Heron items get a third side that usually closes a triangle.
            if (r.cmd == CMD_HERON && $urandom_range(0, 3) != 0)
                r.third_length = 16'($urandom_range(
                    (r.side_a > r.side_b ? r.side_a - r.side_b : r.side_b - r.side_a),
                    (int'(r.side_a) + int'(r.side_b) > 32767)
                        ? 32767 : int'(r.side_a) + int'(r.side_b)));
        end
        return r;
    endfunction

    // Offer one request and hold it until it is taken, after a random gap.
    task automatic send_request(input tau_req_t r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        pending_areas.push_back(predict_area(r));
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Stimulus: directed table, a burst during the long stall, then random requests.
    initial
    begin
        dir_row_t table_rows[$];
        tau_req_t r;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        stim_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        table_rows.push_back(row(mk(CMD_BASE_HEIGHT, 0, 0, 0, 0), 1, 29'd0, 1));
        table_rows.push_back(row(mk(CMD_BASE_HEIGHT, -1, 32767, 32767, -1), 1,
                                 29'd536838144, 1));
        table_rows.push_back(row(mk(CMD_BASE_HEIGHT, 5, -1, 4, 0), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_BASE_HEIGHT, 5, 4, -32768, 0), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_BASE_HEIGHT, 0, 512, 768, 0), 1, 29'd196608, 1));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 256, 256, 0, 0), 1, 29'd0, 1));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 256, 256, 0, -1), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 256, 256, 0, 23040), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 256, 256, 0, 32767), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, -1, 256, 0, 100), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 256, -32768, 0, 100), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 256, 256, 0, 11520), 0, 0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 32767, 32767, 0, 11520), 0, 0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 32767, 32767, 0, 23039), 0, 0, 0));
        table_rows.push_back(row(mk(CMD_SIDE_ANGLE, 300, 700, 0, 3840), 0, 0, 0));
        table_rows.push_back(row(mk(CMD_HERON, 768, 1024, 1280, 0), 1, 29'd393216, 1));
        table_rows.push_back(row(mk(CMD_HERON, 256, 256, 512, 0), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_HERON, 512, 256, 256, 0), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_HERON, 256, 512, 256, 0), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_HERON, -256, 256, 256, 0), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_HERON, 32767, 32767, 32767, 0), 0, 0, 0));
        table_rows.push_back(row(mk(CMD_HERON, 1, 1, 1, 0), 0, 0, 0));
        table_rows.push_back(row(mk(CMD_INVALID, 256, 256, 256, 100), 1, 29'd0, 0));
        table_rows.push_back(row(mk(CMD_INVALID, -1, -1, -1, -1), 1, 29'd0, 0));

        foreach (table_rows[i])
        begin
            send_request(table_rows[i].r);
            // A typed-in result replaces the predicted one for this row.
            if (table_rows[i].has_exp)
                pending_areas[pending_areas.size() - 1] = table_rows[i].e;
        end
        req_valid <= 1'b0;

        // Keep offering back to back while the receiver holds off.
        wait (hold_off);
        for (int i = 0; i < 60; i++)
        begin
            r = random_request();
            req_valid <= 1'b1;
            req       <= r;
            pending_areas.push_back(predict_area(r));
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
        end

        for (int i = 0; i < N_RANDOM; i++)
            send_request(random_request());
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall: one long hold-off after the table, random gaps otherwise.
    initial
    begin
        int n;
        hold_off  = 1'b0;
        res_stall = 1'b0;
        wait (rst_n);
        repeat (150) @(posedge clk);
        hold_off  = 1'b1;
        res_stall <= 1'b1;
        repeat (200) @(posedge clk);
        forever
        begin
            res_stall <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
                @(posedge clk);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            res_stall <= 1'b1;
            repeat (n) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        tau_res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_areas.size() == 0)
            begin
                $display("%0t: result with nothing expected: area %0d valid %0b",
                         $time, res.area, res.valid_res);
                n_errors++;
            end
            else
            begin
                e = pending_areas.pop_front();
                n_checked++;
                if (res.valid_res)
                    n_valid_seen++;
                if (res.area !== e.area)
                begin
                    $display("%0t: area expected %0d actual %0d", $time, e.area, res.area);
                    n_errors++;
                end
                if (res.valid_res !== e.valid_res)
                begin
                    $display("%0t: valid_res expected %0b actual %0b",
                             $time, e.valid_res, res.valid_res);
                    n_errors++;
                end
            end
        end
    end

    // End of run after the queue drains.
    initial
    begin
        n_errors     = 0;
        n_checked    = 0;
        n_valid_seen = 0;
        wait (stim_done);
        wait (pending_areas.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Checked %0d areas, %0d valid, over all three methods and bad operands.",
                 n_checked, n_valid_seen);
        if (n_errors == 0)
            $display("[triangle_area_unit] OK");
        else
            $display("[triangle_area_unit] ERROR");
        $finish;
    end

    // Timeout.
    initial
    begin
        #400000;
        $display("Timed out with %0d results outstanding.", pending_areas.size());
        $display("[triangle_area_unit] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/tau_pkg.sv
sv/tau_sine.sv
sv/tau_heron.sv
sv/triangle_area_unit.sv
sv/tau_checker.sv
dv/tb_triangle_area_unit.sv
